### hw/rtl/dihw_pkg.sv
// shared types and constants of the horizontal depth-image warp
`timescale 1ns / 1ps
`default_nettype none
package dihw_pkg;

  // line store geometry
  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned LumaAw      = 10;
  localparam int unsigned ChromaAw    = 9;
  localparam int unsigned ColW        = 10;
  localparam int unsigned SampleW     = 8;
  localparam int unsigned LimitW      = 11;
  localparam int unsigned TargetW     = 13;
  localparam int unsigned DispMagW    = 11;
  localparam int unsigned CfgW        = 32;
  localparam int unsigned CfgIdxW     = 2;

  // command queue between front and back
  localparam int unsigned QueueDepth  = 8;
  localparam int unsigned QueuePtrW   = 3;
  localparam int unsigned QueueCntW   = 4;
  localparam int unsigned InflightW   = 3;

  localparam logic [DispMagW-1:0] DispLimit    = 11'd2047;
  localparam logic [LimitW-1:0]   FwReset      = 11'd1024;
  localparam logic [LimitW-1:0]   MaxWidthLim  = 11'd1024;
  localparam logic [SampleW-1:0]  LumaBlank    = 8'h00;
  localparam logic [SampleW-1:0]  ChromaBlank  = 8'h80;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDispGain   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDispOffset = 2'd2;

  typedef enum logic [1:0] {
    OpWarp     = 2'd0,
    OpReadLuma = 2'd1,
    OpReadCb   = 2'd2,
    OpReadCr   = 2'd3
  } dihw_op_e;

  // classified command handed from front to back
  typedef struct packed {
    dihw_op_e                   op;
    logic [ColW-1:0]            addr;    // target for warps, column for reads
    logic                       ok;      // warp landed, or read address in range
    logic signed [TargetW-1:0]  target;  // zero for reads
    logic [SampleW-1:0]         luma;
    logic [SampleW-1:0]         cb;
    logic [SampleW-1:0]         cr;
  } dihw_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/dihw_front.sv
// front: disparity pipeline, bound test and command classification
`timescale 1ns / 1ps
`default_nettype none
module dihw_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic signed [dihw_pkg::CfgW-1:0]  gain_i,
  input  wire logic signed [dihw_pkg::CfgW-1:0]  offset_i,
  input  wire logic [dihw_pkg::LimitW-1:0]       limit_i,
  input  wire logic                              in_valid_i,
  input  wire dihw_pkg::dihw_op_e                in_op_i,
  input  wire logic [dihw_pkg::ColW-1:0]         in_column_i,
  input  wire logic [7:0]                        in_depth_i,
  input  wire logic [dihw_pkg::SampleW-1:0]      in_luma_i,
  input  wire logic [dihw_pkg::SampleW-1:0]      in_cb_i,
  input  wire logic [dihw_pkg::SampleW-1:0]      in_cr_i,
  output logic                                   push_o,
  output dihw_pkg::dihw_cmd_t                    cmd_o,
  output logic [dihw_pkg::InflightW-1:0]         inflight_o
);
  import dihw_pkg::*;

  typedef struct packed {
    dihw_op_e             op;
    logic [ColW-1:0]      column;
    logic [SampleW-1:0]   luma;
    logic [SampleW-1:0]   cb;
    logic [SampleW-1:0]   cr;
  } item_t;

  logic [4:0] v_q;

  item_t              it1_q, it2_q, it3_q, it4_q;
  logic signed [40:0] prod_q;
  logic signed [41:0] acc_q;
  logic [41:0]        mag_q;
  logic               neg3_q, neg4_q;
  logic [DispMagW-1:0] dmag_q;
  dihw_cmd_t          cmd_q;

  logic signed [41:0]  acc_d;
  logic [41:0]         mag_d;
  logic [42:0]         rnd_sum;
  logic [26:0]         rnd;
  logic [DispMagW-1:0] dmag_d;
  logic [TargetW-1:0]  col_ext;
  logic [TargetW-1:0]  dm_ext;
  logic signed [TargetW-1:0] target;
  logic                in_frame;
  dihw_cmd_t           cmd_d;

  // valid bits of the five stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  // stage 2: add offset
  assign acc_d = 42'(prod_q) + 42'(offset_i);

  // stage 3: magnitude
  assign mag_d = acc_q[41] ? 42'(-acc_q) : 42'(acc_q);

  // stage 4: round half away from zero, saturate
  assign rnd_sum = {1'b0, mag_q} + 43'h8000;
  assign rnd     = rnd_sum[42:16];
  assign dmag_d  = (rnd > 27'(DispLimit)) ? DispLimit : rnd[DispMagW-1:0];

  // stage 5: target column and bound test
  assign col_ext  = {{(TargetW-ColW){1'b0}}, it4_q.column};
  assign dm_ext   = {{(TargetW-DispMagW){1'b0}}, dmag_q};
  assign target   = neg4_q ? $signed(col_ext - dm_ext) : $signed(col_ext + dm_ext);
  assign in_frame = !target[TargetW-1] && (target[TargetW-2:0] < {1'b0, limit_i});

  always_comb begin
    cmd_d      = '0;
    cmd_d.op   = it4_q.op;
    cmd_d.luma = it4_q.luma;
    cmd_d.cb   = it4_q.cb;
    cmd_d.cr   = it4_q.cr;
    case (it4_q.op)
      OpWarp: begin
        cmd_d.addr   = target[ColW-1:0];
        cmd_d.ok     = in_frame;
        cmd_d.target = target;
      end
      OpReadLuma: begin
        cmd_d.addr = it4_q.column;
        cmd_d.ok   = 1'b1;
      end
      default: begin
        // chroma stores hold half a line
        cmd_d.addr = it4_q.column;
        cmd_d.ok   = !it4_q.column[ColW-1];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    it1_q  <= '{op: in_op_i, column: in_column_i, luma: in_luma_i, cb: in_cb_i, cr: in_cr_i};
    prod_q <= 41'(gain_i) * 41'($signed({1'b0, in_depth_i}));
    it2_q  <= it1_q;
    acc_q  <= acc_d;
    it3_q  <= it2_q;
    mag_q  <= mag_d;
    neg3_q <= acc_q[41];
    it4_q  <= it3_q;
    dmag_q <= dmag_d;
    neg4_q <= neg3_q;
    cmd_q  <= cmd_d;
  end

  assign push_o     = v_q[4];
  assign cmd_o      = cmd_q;
  assign inflight_o = InflightW'({2'b0, v_q[0]} + {2'b0, v_q[1]} + {2'b0, v_q[2]}
                                 + {2'b0, v_q[3]} + {2'b0, v_q[4]});

endmodule
`default_nettype wire

### hw/rtl/dihw_queue.sv
// command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module dihw_queue (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  input  wire dihw_pkg::dihw_cmd_t             cmd_i,
  input  wire logic                            pop_i,
  output logic                                 valid_o,
  output dihw_pkg::dihw_cmd_t                  head_o,
  output logic [dihw_pkg::QueueCntW-1:0]       count_o
);
  import dihw_pkg::*;

  dihw_cmd_t             slot_q [QueueDepth];
  logic [QueuePtrW-1:0]  wptr_q, rptr_q;
  logic [QueueCntW-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QueuePtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QueueCntW'(1);
        2'b01:   cnt_q <= cnt_q - QueueCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rptr_q];
  assign count_o = cnt_q;

endmodule
`default_nettype wire

### hw/rtl/dihw_back.sv
// back: line stores, clearing pass, read-and-clear and result register
`timescale 1ns / 1ps
`default_nettype none
module dihw_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_valid_i,
  input  wire dihw_pkg::dihw_cmd_t             q_head_i,
  output logic                                 q_pop_o,
  output logic                                 ready_o,
  output logic                                 res_valid_o,
  input  wire logic                            res_ready_i,
  output logic [dihw_pkg::SampleW-1:0]         read_data_o,
  output logic                                 landed_o,
  output logic signed [dihw_pkg::TargetW-1:0]  target_o
);
  import dihw_pkg::*;

  logic [SampleW-1:0] luma_mem [MaxWidth];
  logic [SampleW-1:0] cb_mem   [MaxWidth/2];
  logic [SampleW-1:0] cr_mem   [MaxWidth/2];

  logic [LumaAw:0] clr_q;
  logic            done;
  logic            pop;
  logic            warp_land;

  logic                luma_we, cb_we, cr_we;
  logic [LumaAw-1:0]   luma_addr;
  logic [ChromaAw-1:0] chroma_addr;
  logic [SampleW-1:0]  luma_wdata, cb_wdata, cr_wdata;

  logic [SampleW-1:0]        luma_rd_q, cb_rd_q, cr_rd_q;
  logic                      res_valid_q;
  dihw_op_e                  res_op_q;
  logic                      res_ok_q;
  logic signed [TargetW-1:0] res_target_q;

  assign done      = clr_q[LumaAw];
  assign pop       = done && q_valid_i && (!res_valid_q || res_ready_i);
  assign warp_land = (q_head_i.op == OpWarp) && q_head_i.ok;

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (!done) begin
      clr_q <= clr_q + (LumaAw+1)'(1);
    end
  end

  always_comb begin
    if (!done) begin
      luma_we     = 1'b1;
      cb_we       = 1'b1;
      cr_we       = 1'b1;
      luma_addr   = clr_q[LumaAw-1:0];
      chroma_addr = clr_q[ChromaAw-1:0];
      luma_wdata  = LumaBlank;
      cb_wdata    = ChromaBlank;
      cr_wdata    = ChromaBlank;
    end else begin
      luma_we     = pop && (warp_land || (q_head_i.op == OpReadLuma));
      cb_we       = pop && (warp_land || ((q_head_i.op == OpReadCb) && q_head_i.ok));
      cr_we       = pop && (warp_land || ((q_head_i.op == OpReadCr) && q_head_i.ok));
      luma_addr   = q_head_i.addr;
      // warps land chroma at half the target column
      chroma_addr = (q_head_i.op == OpWarp) ? q_head_i.addr[ColW-1:1]
                                            : q_head_i.addr[ChromaAw-1:0];
      luma_wdata  = (q_head_i.op == OpWarp) ? q_head_i.luma : LumaBlank;
      cb_wdata    = (q_head_i.op == OpWarp) ? q_head_i.cb : ChromaBlank;
      cr_wdata    = (q_head_i.op == OpWarp) ? q_head_i.cr : ChromaBlank;
    end
  end

  // stores: read returns the old entry, the blank write lands the same edge
  always_ff @(posedge clk_i) begin
    if (pop) begin
      luma_rd_q <= luma_mem[luma_addr];
    end
    if (luma_we) begin
      luma_mem[luma_addr] <= luma_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cb_rd_q <= cb_mem[chroma_addr];
    end
    if (cb_we) begin
      cb_mem[chroma_addr] <= cb_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cr_rd_q <= cr_mem[chroma_addr];
    end
    if (cr_we) begin
      cr_mem[chroma_addr] <= cr_wdata;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pop) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_op_q     <= q_head_i.op;
      res_ok_q     <= q_head_i.ok;
      res_target_q <= q_head_i.target;
    end
  end

  always_comb begin
    read_data_o = '0;
    if (res_ok_q) begin
      case (res_op_q)
        OpReadLuma: read_data_o = luma_rd_q;
        OpReadCb:   read_data_o = cb_rd_q;
        OpReadCr:   read_data_o = cr_rd_q;
        default:    read_data_o = '0;
      endcase
    end
  end

  assign landed_o    = (res_op_q == OpWarp) && res_ok_q;
  assign target_o    = res_target_q;
  assign res_valid_o = res_valid_q;
  assign q_pop_o     = pop;
  assign ready_o     = done;

endmodule
`default_nettype wire

### hw/rtl/depth_image_horizontal_warp.sv
// top level of the horizontal depth-image warp with line stores
// path: an accepted transaction passes the 5 front stages, a queue slot and the registered
//   store access before m_axis_tvalid rises
// throughput: one transaction per cycle unless the output stalls, one store access per item
// reset: config registers take their reset values; a clearing pass then sweeps the
//   stores (luma to 0, chroma to 128) with s_axis_tready held low
`timescale 1ns / 1ps
`default_nettype none
module depth_image_horizontal_warp (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // column[9:0], depth, luma, cb, cr, zero pad
  input  wire logic [1:0]  s_axis_tuser,   // opcode
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // read_data[7:0], landed, target_column[12:0], pad
);
  import dihw_pkg::*;

  // config registers
  logic [LimitW-1:0]        fw_q;
  logic signed [CfgW-1:0]   gain_q;
  logic signed [CfgW-1:0]   offset_q;
  logic [LimitW-1:0]        limit;

  logic                     accept;
  logic                     push;
  dihw_cmd_t                push_cmd;
  logic [InflightW-1:0]     inflight;
  logic                     q_valid;
  dihw_cmd_t                q_head;
  logic                     q_pop;
  logic [QueueCntW-1:0]     q_count;
  logic [QueueCntW:0]       committed;
  logic                     back_ready;

  logic [SampleW-1:0]        read_data;
  logic                      landed;
  logic signed [TargetW-1:0] target;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= FwReset;
      gain_q   <= '0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFrameWidth: fw_q     <= cfg_data_i[LimitW-1:0];
        CfgDispGain:   gain_q   <= $signed(cfg_data_i);
        CfgDispOffset: offset_q <= $signed(cfg_data_i);
        default: ;  // unlisted index is ignored
      endcase
    end
  end

  // widths beyond the store act as the store width
  assign limit = (fw_q > MaxWidthLim) ? MaxWidthLim : fw_q;

  // credit check: every item in the front pipeline already owns a queue slot
  assign committed     = {1'b0, q_count} + (QueueCntW+1)'(inflight);
  assign s_axis_tready = back_ready && (committed < (QueueCntW+1)'(QueueDepth));
  assign accept        = s_axis_tvalid && s_axis_tready;

  dihw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (gain_q),
    .offset_i    (offset_q),
    .limit_i     (limit),
    .in_valid_i  (accept),
    .in_op_i     (dihw_op_e'(s_axis_tuser)),
    .in_column_i (s_axis_tdata[9:0]),
    .in_depth_i  (s_axis_tdata[17:10]),
    .in_luma_i   (s_axis_tdata[25:18]),
    .in_cb_i     (s_axis_tdata[33:26]),
    .in_cr_i     (s_axis_tdata[41:34]),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .inflight_o  (inflight)
  );

  dihw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head),
    .count_o (q_count)
  );

  dihw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .ready_o     (back_ready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .read_data_o (read_data),
    .landed_o    (landed),
    .target_o    (target)
  );

  assign m_axis_tdata = {2'b00, target, landed, read_data};

endmodule
`default_nettype wire
